// File: sv/tct_pkg.sv
// Shared types, constants and command encoding for the text console teletype.
// Used by tct_front, tct_queue, tct_back and text_console_teletype_top.
package tct_pkg;

   // Screen geometry
   localparam int COLUMNS      = 80;
   localparam int ROWS         = 25;
   localparam int TAB_WIDTH    = 8;
   localparam int CELL_COUNT   = COLUMNS * ROWS;

   // Derived widths
   localparam int ADDR_BITS    = $clog2(CELL_COUNT);
   localparam int COL_BITS     = $clog2(COLUMNS);
   localparam int COL_SUM_BITS = $clog2(COLUMNS + TAB_WIDTH + 1);
   localparam int ROW_BITS     = $clog2(ROWS);
   localparam int ROW_SUM_BITS = $clog2(ROWS + 1);
   localparam int PHASE_BITS   = $clog2(TAB_WIDTH);

   // Fixed field widths
   localparam int TYPE_WIDTH   = 2;
   localparam int CHAR_WIDTH   = 8;
   localparam int LOC_WIDTH    = 11;
   localparam int CELL_WIDTH   = 16;
   localparam int TDATA_WIDTH  = 32;
   localparam int RSP_PAD      = TDATA_WIDTH - LOC_WIDTH - CELL_WIDTH - 1;

   // Scroll sweep: last source row start
   localparam int SCROLL_COPY_LAST = CELL_COUNT - COLUMNS;

   // Command queue
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Request kinds on req_tuser
   localparam logic [TYPE_WIDTH-1:0] REQ_PUT   = 2'd0;
   localparam logic [TYPE_WIDTH-1:0] REQ_CLEAR = 2'd1;
   localparam logic [TYPE_WIDTH-1:0] REQ_READ  = 2'd2;

   // Character codes
   localparam logic [CHAR_WIDTH-1:0] CODE_BS       = 8'h08;
   localparam logic [CHAR_WIDTH-1:0] CODE_TAB      = 8'h09;
   localparam logic [CHAR_WIDTH-1:0] CODE_LF       = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CODE_CR       = 8'h0D;
   localparam logic [CHAR_WIDTH-1:0] CODE_PRINT_LO = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CODE_PRINT_HI = 8'h7F;
   localparam logic [CHAR_WIDTH-1:0] BLANK_CHAR    = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] BS_ATTR       = 8'h0F;
   localparam logic [CHAR_WIDTH-1:0] SCROLL_ATTR   = 8'h07;

   // Decoded operation
   typedef enum logic [2:0] {
      OP_PRINT,
      OP_BACKSPACE,
      OP_TAB,
      OP_CR,
      OP_LF,
      OP_NOP,
      OP_CLEAR,
      OP_READ
   } tct_op_type;

   // Command passed from front to back
   typedef struct packed {
      tct_op_type                op;
      logic [CHAR_WIDTH-1:0]     char_code;
      logic [CHAR_WIDTH-1:0]     char_attr;
      logic [LOC_WIDTH-1:0]      cell_index;
   } tct_cmd_type;

   // Back end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_EXEC,
      BK_READ_WAIT,
      BK_CLEAR,
      BK_SCROLL_COPY,
      BK_SCROLL_FILL,
      BK_DONE
   } tct_back_state_type;

endpackage

// File: sv/tct_front.sv
// Front end: accepts request items, decodes them into commands and holds one
// decoded command until the queue takes it. Depends on tct_pkg.
module tct_front
   import tct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [TDATA_WIDTH-1:0]  req_tdata,
   input  logic [TYPE_WIDTH-1:0]   req_tuser,
   output logic                    q_valid,
   input  logic                    q_ready,
   output tct_cmd_type             q_cmd
);

   logic        hold_valid_ff, hold_valid_in;
   tct_cmd_type hold_cmd_ff, hold_cmd_in;
   tct_cmd_type dec_cmd;
   logic [CHAR_WIDTH-1:0] code;
   logic        accept;

   // Field extraction and classification
   always_comb begin
      code                 = req_tdata[CHAR_WIDTH-1:0];
      dec_cmd.char_code    = code;
      dec_cmd.char_attr    = req_tdata[2*CHAR_WIDTH-1:CHAR_WIDTH];
      dec_cmd.cell_index   = req_tdata[2*CHAR_WIDTH+LOC_WIDTH-1:2*CHAR_WIDTH];
      case (req_tuser)
         REQ_PUT: begin
            if (code == CODE_BS) begin
               dec_cmd.op = OP_BACKSPACE;
            end else if (code == CODE_TAB) begin
               dec_cmd.op = OP_TAB;
            end else if (code == CODE_CR) begin
               dec_cmd.op = OP_CR;
            end else if (code == CODE_LF) begin
               dec_cmd.op = OP_LF;
            end else if (code >= CODE_PRINT_LO && code <= CODE_PRINT_HI) begin
               dec_cmd.op = OP_PRINT;
            end else begin
               dec_cmd.op = OP_NOP;
            end
         end
         REQ_CLEAR: dec_cmd.op = OP_CLEAR;
         REQ_READ:  dec_cmd.op = OP_READ;
         default:   dec_cmd.op = OP_NOP;
      endcase
   end

   // Holding stage
   assign req_tready = !hold_valid_ff || q_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      hold_valid_in = hold_valid_ff && !q_ready;
      hold_cmd_in   = hold_cmd_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = dec_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

   assign q_valid = hold_valid_ff;
   assign q_cmd   = hold_cmd_ff;

endmodule

// File: sv/tct_queue.sv
// Short command queue between front end and back end.
// Depends on tct_pkg for the command type and depth.
module tct_queue
   import tct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  tct_cmd_type push_cmd,
   output logic        pop_valid,
   input  logic        pop_ready,
   output tct_cmd_type pop_cmd
);

   tct_cmd_type entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic push, pop;

   assign push_ready = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                   : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: sv/tct_back.sv
// Back end: cursor logic, screen buffer memory, clear and scroll sweeps and
// the result register. Depends on tct_pkg.
module tct_back
   import tct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  tct_cmd_type             pop_cmd,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [TDATA_WIDTH-1:0]  rsp_tdata
);

   tct_back_state_type state_ff, state_in;
   tct_cmd_type        cmd_ff, cmd_in;
   logic [COL_BITS-1:0]   col_ff, col_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [ADDR_BITS-1:0]  cnt_ff, cnt_in;
   logic                  scroll_ff, scroll_in;
   logic                  in_range_ff, in_range_in;
   logic [CELL_WIDTH-1:0] data_ff, data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   // Screen buffer
   logic [CELL_WIDTH-1:0] mem [CELL_COUNT];
   logic [CELL_WIDTH-1:0] rd_data_ff;
   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_wa, mem_ra;
   logic [CELL_WIDTH-1:0] mem_wd;

   // Put datapath
   logic [COL_SUM_BITS-1:0] col_sum;
   logic [ROW_SUM_BITS-1:0] row_sum;
   logic [PHASE_BITS-1:0]   phase_new;
   logic [COL_BITS-1:0]     put_col;
   logic                    put_we;
   logic [CHAR_WIDTH-1:0]   put_char, put_attr;
   logic [ADDR_BITS-1:0]    put_addr;
   logic                    scroll_needed;
   logic [COL_BITS-1:0]     col_next;
   logic [ROW_BITS-1:0]     row_next;
   logic [ADDR_BITS-1:0]    cur_loc;
   logic                    idx_in_range;
   logic                    out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign cur_loc      = ADDR_BITS'(row_ff * COLUMNS) + ADDR_BITS'(col_ff);
   assign idx_in_range = 32'(cmd_ff.cell_index) < 32'(CELL_COUNT);

   // Cursor movement for a put command
   always_comb begin
      col_sum   = COL_SUM_BITS'(col_ff);
      row_sum   = ROW_SUM_BITS'(row_ff);
      phase_new = phase_ff;
      put_col   = col_ff;
      put_we    = 1'b0;
      put_char  = BLANK_CHAR;
      put_attr  = BS_ATTR;
      case (cmd_ff.op)
         OP_PRINT: begin
            put_we    = 1'b1;
            put_char  = cmd_ff.char_code;
            put_attr  = cmd_ff.char_attr;
            col_sum   = COL_SUM_BITS'(col_ff) + 1'b1;
            phase_new = (phase_ff == PHASE_BITS'(TAB_WIDTH - 1)) ? '0 : phase_ff + 1'b1;
         end
         OP_BACKSPACE: begin
            if (col_ff != '0) begin
               put_we    = 1'b1;
               put_col   = col_ff - 1'b1;
               col_sum   = COL_SUM_BITS'(col_ff) - 1'b1;
               phase_new = (phase_ff == '0) ? PHASE_BITS'(TAB_WIDTH - 1) : phase_ff - 1'b1;
            end
         end
         OP_TAB: begin
            col_sum   = COL_SUM_BITS'(col_ff) + COL_SUM_BITS'(TAB_WIDTH)
                      - COL_SUM_BITS'(phase_ff);
            phase_new = '0;
         end
         OP_CR: begin
            col_sum   = '0;
            phase_new = '0;
         end
         OP_LF: begin
            col_sum   = '0;
            row_sum   = row_sum + 1'b1;
            phase_new = '0;
         end
         default: begin
         end
      endcase
      // wrap at end of line
      if (col_sum >= COL_SUM_BITS'(COLUMNS)) begin
         col_sum   = '0;
         row_sum   = row_sum + 1'b1;
         phase_new = '0;
      end
      scroll_needed = row_sum == ROW_SUM_BITS'(ROWS);
      col_next      = COL_BITS'(col_sum);
      row_next      = scroll_needed ? ROW_BITS'(ROWS - 1) : ROW_BITS'(row_sum);
      put_addr      = ADDR_BITS'(row_ff * COLUMNS) + ADDR_BITS'(put_col);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            case (cmd_ff.op)
               OP_READ:  state_in = BK_READ_WAIT;
               OP_CLEAR: state_in = BK_CLEAR;
               default:  state_in = scroll_needed ? BK_SCROLL_COPY : BK_DONE;
            endcase
         end
         BK_READ_WAIT: state_in = BK_DONE;
         BK_CLEAR: begin
            if (cnt_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_SCROLL_COPY: begin
            if (cnt_ff == ADDR_BITS'(SCROLL_COPY_LAST)) begin
               state_in = BK_SCROLL_FILL;
            end
         end
         BK_SCROLL_FILL: begin
            if (cnt_ff == ADDR_BITS'(CELL_COUNT - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs and datapath updates
   always_comb begin
      pop_ready    = 1'b0;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      scroll_in    = scroll_ff;
      in_range_in  = in_range_ff;
      data_in      = data_ff;
      mem_we       = 1'b0;
      mem_wa       = cnt_ff;
      mem_wd       = {cmd_ff.char_attr, BLANK_CHAR};
      mem_ra       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cmd_in    = pop_cmd;
               scroll_in = 1'b0;
               data_in   = '0;
            end
         end
         BK_EXEC: begin
            case (cmd_ff.op)
               OP_READ: begin
                  in_range_in = idx_in_range;
                  mem_ra      = idx_in_range ? ADDR_BITS'(cmd_ff.cell_index) : '0;
               end
               OP_CLEAR: begin
                  cnt_in   = '0;
                  col_in   = '0;
                  row_in   = '0;
                  phase_in = '0;
               end
               default: begin
                  mem_we    = put_we;
                  mem_wa    = put_addr;
                  mem_wd    = {put_attr, put_char};
                  col_in    = col_next;
                  row_in    = row_next;
                  phase_in  = phase_new;
                  scroll_in = scroll_needed;
                  cnt_in    = '0;
               end
            endcase
         end
         BK_READ_WAIT: begin
            data_in = in_range_ff ? rd_data_ff : '0;
         end
         BK_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = {cmd_ff.char_attr, BLANK_CHAR};
            cnt_in = cnt_ff + 1'b1;
         end
         BK_SCROLL_COPY: begin
            // read one row ahead, write back the cell read last cycle
            if (cnt_ff != ADDR_BITS'(SCROLL_COPY_LAST)) begin
               mem_ra = cnt_ff + ADDR_BITS'(COLUMNS);
               cnt_in = cnt_ff + 1'b1;
            end
            if (cnt_ff != '0) begin
               mem_we = 1'b1;
               mem_wa = cnt_ff - 1'b1;
               mem_wd = rd_data_ff;
            end
         end
         BK_SCROLL_FILL: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = {SCROLL_ATTR, BLANK_CHAR};
            cnt_in = cnt_ff + 1'b1;
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD{1'b0}}, scroll_ff, data_ff, LOC_WIDTH'(cur_loc)};
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      scroll_ff   <= scroll_in;
      in_range_ff <= in_range_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Buffer memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[mem_ra];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/text_console_teletype_top.sv
// Top level of the text console teletype: front end, command queue, back end.
// Depends on tct_pkg, tct_front, tct_queue and tct_back.
//
// An 80x25 text console with cursor. Each request item on req_ gives exactly
// one result item on rsp_. A put (req_tuser 0) handles backspace, tab, CR, LF
// and printable codes 0x20..0x7F; a clear (1) fills the screen with spaces in
// the given attribute and homes the cursor; a read (2) returns one cell. A put
// passes the front end holding register, the queue and back end states IDLE,
// EXEC and DONE to the result register; a read also passes READ_WAIT. The back
// end works on one command at a time; the front end and a 2-entry queue accept
// further items meanwhile. A clear blanks every cell and a put that scrolls
// copies 1920 cells with a registered read-ahead, then blanks the last row;
// both hold the back end since the single write port moves one cell a cycle.
// Reading a cell that was never cleared or written returns undefined data.
module text_console_teletype_top
   import tct_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // char_code[7:0], char_attr[15:8], cell_index[26:16], zero[31:27]
   input  logic [TDATA_WIDTH-1:0]  req_tdata,
   // req_type[1:0]
   input  logic [TYPE_WIDTH-1:0]   req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // cursor_location[10:0], cell_data[26:11], scrolled[27], zero[31:28]
   output logic [TDATA_WIDTH-1:0]  rsp_tdata
);

   logic        fq_valid, fq_ready;
   tct_cmd_type fq_cmd;
   logic        qb_valid, qb_ready;
   tct_cmd_type qb_cmd;

   tct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (fq_valid),
      .q_ready    (fq_ready),
      .q_cmd      (fq_cmd)
   );

   tct_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   tct_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
